FILE: sv/fdlt_pkg.sv
// Shared types and constants for the fault debounce and latch table.
`timescale 1ns / 1ps
`default_nettype none
package fdlt_pkg;

    localparam int          DEF_FAULTS  = 256;
    localparam logic [15:0] DEF_TIME    = 16'd100;
    localparam logic [2:0]  LATCH_GRADE = 3'd3;

    // Configuration register indexes
    localparam logic REG_CONFIRM = 1'b0;
    localparam logic REG_PERIOD  = 1'b1;

    // Decoded request passed from front to back
    typedef struct packed {
        logic       is_end;
        logic       in_range;
        logic [7:0] idx;
        logic       act;
        logic [2:0] grade;
        logic [2:0] part;
        logic [2:0] bms;
        logic [2:0] mcu;
    } t_req;

    // Latched fault record
    typedef struct packed {
        logic [7:0] num;
        logic [2:0] grade;
        logic [2:0] part;
    } t_entry;

    // One table row: record plus debounce counter
    typedef struct packed {
        t_entry      ent;
        logic [15:0] cnt;
    } t_row;

    // Status from back to front
    typedef struct packed {
        logic clearing;
        logic pop;
    } t_bstat;

endpackage
`default_nettype wire

FILE: sv/fault_debounce_latch_table_top.sv
// Top level of the fault debounce and latch table.
// Usage:
//   Input channel (i_valid/o_ready) carries one request: i_cmd = 0 reports a
//   fault (index, active, grade, part), i_cmd = 1 ends the task cycle and
//   supplies the battery and motor levels. Each request gives exactly one
//   result on the output channel (o_valid/i_ready).
//   Configuration: i_cfg_we with i_cfg_idx 0 (confirm time) or 1 (display
//   period) and 16-bit i_cfg_data. The user must have these taken only
//   while idle; the block itself does not enforce it.
//   Sequence: a fault report gives its result after a registered table read,
//   then update and write-back; an out-of-range report answers without the
//   table. A cycle end sweeps the table one row per cycle, then gives its
//   result from a wrap-up state. The back end starts a request only once the
//   previous result has left, so it never begins one while a result waits.
//   A two-entry request queue sits ahead of the back end, so requests are
//   taken while a result waits. A stalled receiver holds the result and
//   fills the queue, then o_ready drops.
//   Reset: synchronous, active low. After reset the table is cleared row by
//   row, during which o_ready stays low. Confirm time and display period
//   return to 100.
`timescale 1ns / 1ps
`default_nettype none
module fault_debounce_latch_table_top import fdlt_pkg::*; #(
    parameter int NUM_FAULTS = DEF_FAULTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_cmd,
    input  wire  [7:0]  i_fault_index,
    input  wire         i_fault_active,
    input  wire  [2:0]  i_fault_grade,
    input  wire  [2:0]  i_fault_part,
    input  wire  [2:0]  i_bms_level,
    input  wire  [2:0]  i_mcu_level,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_entry_set,
    output logic [2:0]  o_entry_grade,
    output logic [2:0]  o_entry_part,
    output logic [2:0]  o_vcu_level,
    output logic [2:0]  o_vehicle_level,
    output logic [8:0]  o_active_count,
    output logic [7:0]  o_shown_code
);

    t_req   req;
    logic   req_valid;
    t_bstat bstat;

    fdlt_front #(.NUM_FAULTS(NUM_FAULTS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_fault_index  (i_fault_index),
        .i_fault_active (i_fault_active),
        .i_fault_grade  (i_fault_grade),
        .i_fault_part   (i_fault_part),
        .i_bms_level    (i_bms_level),
        .i_mcu_level    (i_mcu_level),
        .i_bstat        (bstat),
        .o_req          (req),
        .o_req_valid    (req_valid)
    );

    fdlt_back #(.NUM_FAULTS(NUM_FAULTS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_req           (req),
        .i_req_valid     (req_valid),
        .o_bstat         (bstat),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_entry_set     (o_entry_set),
        .o_entry_grade   (o_entry_grade),
        .o_entry_part    (o_entry_part),
        .o_vcu_level     (o_vcu_level),
        .o_vehicle_level (o_vehicle_level),
        .o_active_count  (o_active_count),
        .o_shown_code    (o_shown_code)
    );

endmodule
`default_nettype wire

FILE: sv/fdlt_front.sv
// Front end: request decode and a two-entry queue towards the back end.
`timescale 1ns / 1ps
`default_nettype none
module fdlt_front import fdlt_pkg::*; #(
    parameter int NUM_FAULTS = DEF_FAULTS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire        i_cmd,
    input  wire  [7:0] i_fault_index,
    input  wire        i_fault_active,
    input  wire  [2:0] i_fault_grade,
    input  wire  [2:0] i_fault_part,
    input  wire  [2:0] i_bms_level,
    input  wire  [2:0] i_mcu_level,
    input  t_bstat     i_bstat,
    output t_req       o_req,
    output logic       o_req_valid
);

    t_req       r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    t_req       req_in;
    logic       push;

    // Classify the incoming request
    always_comb begin
        req_in.is_end   = i_cmd;
        req_in.in_range = (32'(i_fault_index) < NUM_FAULTS);
        req_in.idx      = i_fault_index;
        req_in.act      = i_fault_active;
        req_in.grade    = i_fault_grade;
        req_in.part     = i_fault_part;
        req_in.bms      = i_bms_level;
        req_in.mcu      = i_mcu_level;
    end

    // Hold off requests while full or while the table is being cleared
    assign o_ready     = (r_count != 2'd2) && !i_bstat.clearing;
    assign push        = i_valid && o_ready;
    assign o_req       = r_q[r_rptr];
    assign o_req_valid = (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= req_in;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_bstat.pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_bstat.pop);
        end
    end

endmodule
`default_nettype wire

FILE: sv/fdlt_back.sv
// Back end: fault table memory, report update, cycle-end scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module fdlt_back import fdlt_pkg::*; #(
    parameter int NUM_FAULTS = DEF_FAULTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    input  t_req        i_req,
    input  wire         i_req_valid,
    output t_bstat      o_bstat,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_entry_set,
    output logic [2:0]  o_entry_grade,
    output logic [2:0]  o_entry_part,
    output logic [2:0]  o_vcu_level,
    output logic [2:0]  o_vehicle_level,
    output logic [8:0]  o_active_count,
    output logic [7:0]  o_shown_code
);

    localparam int          AW   = $clog2(NUM_FAULTS);
    localparam logic [AW-1:0] LAST = AW'(NUM_FAULTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RMW   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    t_row         r_mem [NUM_FAULTS];
    t_row         r_rdata;
    t_req         r_req;
    logic [AW-1:0] r_addr, n_addr;
    logic [15:0]  r_ct, r_period, r_tick;
    logic [8:0]   r_pos, r_cnt;
    logic [2:0]   r_vmax;
    logic [7:0]   r_first, r_nth;
    logic         r_first_ok;

    logic         start, mem_we;
    logic [AW-1:0] rd_addr, wr_addr;
    t_row         wr_data;
    logic [16:0]  cnt_inc, tick_inc;
    logic         conf;
    logic [15:0]  cnt_new;
    t_entry       ent_new;
    logic [2:0]   veh;
    logic [8:0]   pos_adv, pos_new;
    logic [7:0]   shown_new;
    logic         advance;

    assign start = (r_state == S_IDLE) && i_req_valid && !o_valid;
    assign o_bstat.pop      = start;
    assign o_bstat.clearing = (r_state == S_CLEAR);

    // Report update: debounce counter and latch decision
    always_comb begin
        cnt_inc = {1'b0, r_rdata.cnt} + 17'd1;
        conf    = 1'b0;
        cnt_new = 16'd0;
        if (r_req.act) begin
            if (cnt_inc >= {1'b0, r_ct}) begin
                conf    = 1'b1;
                cnt_new = r_ct;
            end else begin
                cnt_new = cnt_inc[15:0];
            end
        end
        if (conf || (r_rdata.ent.grade >= LATCH_GRADE)) begin
            ent_new.num   = r_req.idx;
            ent_new.grade = r_req.grade;
            ent_new.part  = r_req.part;
        end else begin
            ent_new = '0;
        end
    end

    // Cycle-end wrap-up: levels and display step
    always_comb begin
        veh = r_vmax;
        if (r_req.bms > veh) veh = r_req.bms;
        if (r_req.mcu > veh) veh = r_req.mcu;
        tick_inc  = {1'b0, r_tick} + 17'd1;
        advance   = (tick_inc >= {1'b0, r_period});
        shown_new = (r_pos < r_cnt) ? r_nth : r_first;
        pos_adv   = advance ? (r_pos + 9'd1) : r_pos;
        pos_new   = (pos_adv >= r_cnt) ? 9'd0 : pos_adv;
    end

    // Memory port selection
    always_comb begin
        rd_addr = (r_state == S_SCAN) ? (r_addr + AW'(1)) : AW'(i_req.idx);
        if (start && i_req.is_end) begin
            rd_addr = '0;
        end
        mem_we  = (r_state == S_CLEAR) || (r_state == S_RMW);
        wr_addr = (r_state == S_CLEAR) ? r_addr : AW'(r_req.idx);
        wr_data = (r_state == S_CLEAR) ? '0 : t_row'{ent: ent_new, cnt: cnt_new};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Sequence: clear, idle, update or scan
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_addr = '0;
                if (start && i_req.is_end) begin
                    n_state = S_SCAN;
                end else if (start && i_req.in_range) begin
                    n_state = S_RMW;
                end
            end
            S_RMW:  n_state = S_IDLE;
            S_SCAN: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_addr          <= '0;
            r_ct            <= DEF_TIME;
            r_period        <= DEF_TIME;
            r_tick          <= 16'd0;
            r_pos           <= 9'd0;
            r_cnt           <= 9'd0;
            r_vmax          <= 3'd0;
            r_first         <= 8'd0;
            r_nth           <= 8'd0;
            r_first_ok      <= 1'b0;
            o_valid         <= 1'b0;
            o_entry_set     <= 1'b0;
            o_entry_grade   <= 3'd0;
            o_entry_part    <= 3'd0;
            o_vcu_level     <= 3'd0;
            o_vehicle_level <= 3'd0;
            o_active_count  <= 9'd0;
            o_shown_code    <= 8'd0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            // Take configuration writes
            if (i_cfg_we && (i_cfg_idx == REG_CONFIRM)) begin
                r_ct <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == REG_PERIOD)) begin
                r_period <= i_cfg_data;
            end
            // Drop the result once taken
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            // Out-of-range report answers at once with a clear entry
            if (start && !i_req.is_end && !i_req.in_range) begin
                o_valid       <= 1'b1;
                o_entry_set   <= 1'b0;
                o_entry_grade <= 3'd0;
                o_entry_part  <= 3'd0;
            end
            // Arm the scan accumulators
            if (start && i_req.is_end) begin
                r_cnt      <= 9'd0;
                r_vmax     <= 3'd0;
                r_first    <= 8'd0;
                r_nth      <= 8'd0;
                r_first_ok <= 1'b0;
            end
            if (r_state == S_RMW) begin
                o_valid       <= 1'b1;
                o_entry_set   <= (ent_new != '0);
                o_entry_grade <= ent_new.grade;
                o_entry_part  <= ent_new.part;
            end
            // Accumulate one row per cycle
            if (r_state == S_SCAN) begin
                if (r_rdata.ent.grade > r_vmax) begin
                    r_vmax <= r_rdata.ent.grade;
                end
                if (r_rdata.ent.num != 8'd0) begin
                    r_cnt <= r_cnt + 9'd1;
                    if (!r_first_ok) begin
                        r_first    <= r_rdata.ent.num;
                        r_first_ok <= 1'b1;
                    end
                    if (r_cnt == r_pos) begin
                        r_nth <= r_rdata.ent.num;
                    end
                end
            end
            if (r_state == S_FIN) begin
                o_valid         <= 1'b1;
                o_entry_set     <= 1'b0;
                o_entry_grade   <= 3'd0;
                o_entry_part    <= 3'd0;
                o_vcu_level     <= r_vmax;
                o_vehicle_level <= veh;
                o_active_count  <= r_cnt;
                r_pos           <= pos_new;
                if (advance) begin
                    r_tick       <= 16'd0;
                    o_shown_code <= shown_new;
                end else begin
                    r_tick <= tick_inc[15:0];
                end
            end
        end
    end

    // A report update always leaves a result
    a_rmw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |=> o_valid)
        else $error("report update gave no result");

    // A scan wrap-up always leaves a result
    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_valid)
        else $error("cycle end gave no result");

    // Nothing is started or presented while clearing
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_valid && !start))
        else $error("activity during table clear");

    // Work starts only with a free result slot
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !o_valid)
        else $error("request started over a pending result");

endmodule
`default_nettype wire

FILE: dv/tb_fault_debounce_latch_table_top.sv
// Testbench for the fault debounce and latch table: directed table, then random requests.
`timescale 1ns / 1ps
module tb_fault_debounce_latch_table_top;
    import fdlt_pkg::*;

    localparam int NFAULT   = 256;
    localparam int DRAIN    = NFAULT + 40;
    localparam int WD_LIMIT = 6000;
    localparam int HOLD_LEN = 800;

    typedef struct packed {
        logic       set;
        logic [2:0] grade;
        logic [2:0] part;
        logic [2:0] vcu;
        logic [2:0] veh;
        logic [8:0] count;
        logic [7:0] code;
    } t_res;

    typedef struct packed {
        logic       cmd;
        logic [7:0] idx;
        logic       act;
        logic [2:0] grade;
        logic [2:0] part;
        logic [2:0] bms;
        logic [2:0] mcu;
        logic       typed;
        t_res       res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_CONFIRM;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = 1'b0;
    logic [7:0]  i_fault_index = '0;
    logic        i_fault_active = 1'b0;
    logic [2:0]  i_fault_grade = '0;
    logic [2:0]  i_fault_part = '0;
    logic [2:0]  i_bms_level = '0;
    logic [2:0]  i_mcu_level = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_entry_set;
    logic [2:0]  o_entry_grade;
    logic [2:0]  o_entry_part;
    logic [2:0]  o_vcu_level;
    logic [2:0]  o_vehicle_level;
    logic [8:0]  o_active_count;
    logic [7:0]  o_shown_code;

    fault_debounce_latch_table_top u_dut (.*);

    // Predicted table state
    logic [15:0] pr_confirm, pr_period, pr_tick;
    logic [15:0] pr_cnt [NFAULT];
    t_entry      pr_ent [NFAULT];
    logic [8:0]  pr_pos, pr_count;
    logic [7:0]  pr_code;
    logic [2:0]  pr_vcu, pr_veh;

    t_res expected_results[$];
    int   fail_count = 0;
    int   reports_sent = 0, ends_sent = 0, results_seen = 0;
    int   idle_cycles = 0;
    bit   hold_done = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [7:0] nth_code(input int n);
        int seen;
        seen = 0;
        for (int i = 0; i < NFAULT; i++) begin
            if (pr_ent[i].num != 0) begin
                if (seen == n) return pr_ent[i].num;
                seen++;
            end
        end
        return 8'd0;
    endfunction

    // Advance the predicted table by one request and return its result
    function automatic t_res update_table(input t_row r);
        t_res o;
        int   nxt, vcu, veh, cnt;
        bit   conf;
        o = '0;
        if (!r.cmd) begin
            conf = 1'b0;
            if (r.act) begin
                nxt = int'(pr_cnt[r.idx]) + 1;
                if (nxt >= int'(pr_confirm)) begin
                    pr_cnt[r.idx] = pr_confirm;
                    conf = 1'b1;
                end else begin
                    pr_cnt[r.idx] = nxt[15:0];
                end
            end else begin
                pr_cnt[r.idx] = '0;
            end
            if (conf || pr_ent[r.idx].grade >= LATCH_GRADE)
                pr_ent[r.idx] = '{num: r.idx, grade: r.grade, part: r.part};
            else
                pr_ent[r.idx] = '0;
            o.set   = (pr_ent[r.idx] != '0);
            o.grade = pr_ent[r.idx].grade;
            o.part  = pr_ent[r.idx].part;
        end else begin
            vcu = 0;
            cnt = 0;
            for (int i = 0; i < NFAULT; i++) begin
                if (pr_ent[i].grade > vcu) vcu = pr_ent[i].grade;
                if (pr_ent[i].num != 0) cnt++;
            end
            veh = vcu;
            if (r.bms > veh) veh = r.bms;
            if (r.mcu > veh) veh = r.mcu;
            pr_vcu   = vcu[2:0];
            pr_veh   = veh[2:0];
            pr_count = cnt[8:0];
            if (int'(pr_tick) + 1 >= int'(pr_period)) begin
                pr_tick = '0;
                pr_code = (int'(pr_pos) < cnt) ? nth_code(pr_pos) : nth_code(0);
                pr_pos  = pr_pos + 9'd1;
            end else begin
                pr_tick = pr_tick + 16'd1;
            end
            if (int'(pr_pos) >= cnt) pr_pos = '0;
        end
        o.vcu   = pr_vcu;
        o.veh   = pr_veh;
        o.count = pr_count;
        o.code  = pr_code;
        return o;
    endfunction

    // Offer one request after a random gap and hold it until taken
    task automatic send_req(input t_row r);
        int   gap;
        t_res o;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= r.cmd;
        i_fault_index  <= r.idx;
        i_fault_active <= r.act;
        i_fault_grade  <= r.grade;
        i_fault_part   <= r.part;
        i_bms_level    <= r.bms;
        i_mcu_level    <= r.mcu;
        do @(posedge i_clk); while (!o_ready);
        o = update_table(r);
        expected_results.push_back(r.typed ? r.res : o);
        if (r.cmd) ends_sent++; else reports_sent++;
    endtask

    // Write one register once the block has drained
    task automatic write_reg(input logic idx, input logic [15:0] val);
        i_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CONFIRM) pr_confirm = val; else pr_period = val;
    endtask

    function automatic t_row rand_row(input logic [7:0] pool_base);
        t_row r;
        r = '0;
        r.bms = 3'($urandom_range(0, 7));
        r.mcu = 3'($urandom_range(0, 7));
        r.grade = 3'($urandom_range(0, 7));
        r.part  = 3'($urandom_range(0, 7));
        r.act   = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) < 2) r.cmd = 1'b1;
        if ($urandom_range(0, 4) == 0) r.idx = 8'($urandom_range(0, 255));
        else r.idx = pool_base + 8'($urandom_range(0, 7) * 29);
        return r;
    endfunction

    // Receiver: random stalls, one long hold-off, check each result
    always begin
        int   w;
        t_res got, want;
        w = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (!hold_done && results_seen == 60) begin
            hold_done = 1'b1;
            w = HOLD_LEN;
        end
        if (w > 0) begin
            i_ready <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        i_ready <= 1'b1;
        do @(posedge i_clk); while (!(o_valid && i_rst_n));
        got = '{o_entry_set, o_entry_grade, o_entry_part, o_vcu_level,
                o_vehicle_level, o_active_count, o_shown_code};
        results_seen++;
        if (expected_results.size() == 0) begin
            $error("unexpected result with no request outstanding");
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.set !== want.set) begin
                $error("entry_set expected %0d got %0d", want.set, got.set); fail_count++;
            end
            if (got.grade !== want.grade) begin
                $error("entry_grade expected %0d got %0d", want.grade, got.grade);
                fail_count++;
            end
            if (got.part !== want.part) begin
                $error("entry_part expected %0d got %0d", want.part, got.part); fail_count++;
            end
            if (got.vcu !== want.vcu) begin
                $error("vcu_level expected %0d got %0d", want.vcu, got.vcu); fail_count++;
            end
            if (got.veh !== want.veh) begin
                $error("vehicle_level expected %0d got %0d", want.veh, got.veh);
                fail_count++;
            end
            if (got.count !== want.count) begin
                $error("active_count expected %0d got %0d", want.count, got.count);
                fail_count++;
            end
            if (got.code !== want.code) begin
                $error("shown_code expected %0d got %0d", want.code, got.code);
                fail_count++;
            end
        end
    end

    // Watchdog: stop when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else if (expected_results.size() != 0 || i_valid)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Directed requests: typed result where it is obvious, predictor elsewhere
    t_row directed [$];

    initial begin
        t_row r;
        logic [15:0] cfg_list [7][2];
        int          phase_len [7];
        logic [7:0]  base;
        cfg_list = '{'{16'd1, 16'd1}, '{16'd2, 16'd3}, '{16'd3, 16'd1},
                     '{16'd5, 16'd7}, '{16'hFFFF, 16'hFFFF}, '{16'd1, 16'hFFFF},
                     '{16'd4, 16'd2}};
        phase_len = '{120, 100, 100, 100, 40, 60, 120};
        pr_confirm = DEF_TIME;
        pr_period  = DEF_TIME;
        pr_tick = '0; pr_pos = '0; pr_code = '0; pr_vcu = '0; pr_veh = '0; pr_count = '0;
        for (int i = 0; i < NFAULT; i++) begin
            pr_cnt[i] = '0;
            pr_ent[i] = '0;
        end

        // cmd idx act grade part bms mcu typed {set grade part vcu veh count code}
        directed.push_back('{1, 0,   0, 0, 0, 7, 0, 1, '{0, 0, 0, 0, 7, 0, 0}});
        directed.push_back('{1, 0,   0, 0, 0, 0, 5, 1, '{0, 0, 0, 0, 5, 0, 0}});
        directed.push_back('{0, 255, 0, 7, 7, 0, 0, 1, '{0, 0, 0, 0, 5, 0, 0}});
        directed.push_back('{0, 255, 1, 7, 7, 0, 0, 0, '0});
        directed.push_back('{0, 0,   1, 3, 0, 0, 0, 0, '0});
        directed.push_back('{1, 0,   0, 0, 0, 0, 0, 0, '0});
        directed.push_back('{0, 0,   0, 1, 5, 0, 0, 0, '0});
        directed.push_back('{0, 0,   0, 2, 2, 0, 0, 0, '0});
        directed.push_back('{0, 255, 0, 2, 6, 0, 0, 0, '0});
        directed.push_back('{0, 255, 0, 2, 6, 0, 0, 0, '0});
        directed.push_back('{0, 128, 1, 0, 0, 0, 0, 0, '0});
        directed.push_back('{0, 1,   1, 4, 3, 0, 0, 0, '0});
        directed.push_back('{0, 170, 1, 2, 1, 0, 0, 0, '0});
        directed.push_back('{1, 0,   0, 0, 0, 3, 7, 0, '0});
        directed.push_back('{1, 0,   0, 0, 0, 7, 7, 0, '0});
        directed.push_back('{0, 85,  1, 6, 4, 0, 0, 0, '0});
        directed.push_back('{1, 0,   0, 0, 0, 1, 2, 0, '0});
        directed.push_back('{1, 0,   0, 0, 0, 0, 0, 0, '0});
        directed.push_back('{0, 1,   0, 0, 0, 0, 0, 0, '0});
        directed.push_back('{1, 0,   0, 0, 0, 0, 0, 0, '0});

        // Hold reset, then run the first rows at the reset settings
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 3; i++) send_req(directed[i]);
        write_reg(REG_CONFIRM, 16'd1);
        write_reg(REG_PERIOD, 16'd1);
        for (int i = 3; i < directed.size(); i++) send_req(directed[i]);

        // Random phases, each under its own settings
        for (int p = 0; p < 7; p++) begin
            write_reg(REG_CONFIRM, cfg_list[p][0]);
            write_reg(REG_PERIOD, cfg_list[p][1]);
            base = 8'($urandom_range(0, 255));
            for (int k = 0; k < phase_len[p]; k++) begin
                r = rand_row(base);
                send_req(r);
            end
        end

        // Drain and report
        i_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        $display("run: %0d fault reports and %0d cycle ends over nine settings,",
                 reports_sent, ends_sent);
        $display("     %0d results checked, including one long receiver hold-off",
                 results_seen);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
